/* sv/mlq_pkg.sv */
// Package for the multilevel queue round-robin scheduler.
// Holds sizes, operation codes, command and status structs. No dependencies.
`default_nettype none
package mlq_pkg;
    localparam int TASK_SLOTS = 16;
    localparam int LEVELS     = 8;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int LEVEL_W    = $clog2(LEVELS);
    localparam int WORK_W     = 16;
    localparam int QUANT_W    = 16;
    localparam int TIME_W     = 32;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(4);
    localparam logic [1:0] REG_QUANTUM = 2'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input transaction
        logic admit;     // perform the admit
        logic requeue;   // tick phase: re-queue the expired task
        logic preempt;   // tick phase: preempt to the front
        logic run;       // tick phase: dispatch if free and run one unit
    } mlq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
    } mlq_stat_t;
endpackage
`default_nettype wire

/* sv/mlq_datapath.sv */
// Datapath of the scheduler: task tables, level queues and the run logic.
// Depends on mlq_pkg.
`default_nettype none
module mlq_datapath
    import mlq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mlq_cmd_t             cmd,
    output mlq_stat_t                 stat,
    input  wire logic                 in_op,
    input  wire logic [SLOT_W-1:0]    in_slot,
    input  wire logic [WORK_W-1:0]    in_work,
    input  wire logic [2:0]           in_level,
    input  wire logic [QUANT_W-1:0]   quantum,
    output logic [TIME_W+7:0]         result
);
    logic                 op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [WORK_W-1:0]    work_reg;
    logic [LEVEL_W-1:0]   lvl_reg;

    logic [WORK_W-1:0]    rem_reg  [TASK_SLOTS];
    logic [LEVEL_W-1:0]   tlev_reg [TASK_SLOTS];
    logic [SLOT_W-1:0]    link_reg [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] started_reg;
    logic [SLOT_W-1:0]    head_reg [LEVELS];
    logic [SLOT_W-1:0]    tail_reg [LEVELS];
    logic [LEVELS-1:0]    ne_reg;
    logic                 cur_v_reg, exp_v_reg, last_v_reg;
    logic [SLOT_W-1:0]    cur_reg, exp_reg, last_reg;
    logic [LEVEL_W-1:0]   cur_lvl_reg;
    logic [QUANT_W-1:0]   slice_reg;
    logic [TIME_W-1:0]    time_reg;
    logic [TIME_W+7:0]    result_reg;

    assign stat.is_tick = (op_reg == OP_TICK);
    assign result = result_reg;

    // Best non-empty level: priority encoder over queue flags.
    logic                 found;
    logic [LEVEL_W-1:0]   best;
    always_comb
    begin
        found = 1'b0;
        best  = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (ne_reg[i])
            begin
                found = 1'b1;
                best  = LEVEL_W'(i);
            end
        end
    end

    // Input level saturation and the slot chosen for the run phase.
    logic [LEVEL_W-1:0] sat_lvl;
    logic [SLOT_W-1:0]  pick;
    logic [WORK_W-1:0]  rem_dec;
    logic [QUANT_W-1:0] slice_inc;
    always_comb
    begin
        if ({29'd0, in_level} >= LEVELS)
            sat_lvl = LEVEL_W'(LEVELS - 1);
        else
            sat_lvl = in_level[LEVEL_W-1:0];
        pick      = cur_v_reg ? cur_reg : head_reg[best];
        rem_dec   = rem_reg[pick] - WORK_W'(1);
        slice_inc = (cur_v_reg ? slice_reg : '0) + QUANT_W'(1);
    end

    // Sequential update, one phase per command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= OP_ADMIT;
            started_reg <= '0;
            ne_reg      <= '0;
            cur_v_reg   <= 1'b0;
            exp_v_reg   <= 1'b0;
            last_v_reg  <= 1'b0;
            cur_lvl_reg <= '0;
            slice_reg   <= '0;
            time_reg    <= '0;
            for (int i = 0; i < TASK_SLOTS; i++)
                rem_reg[i] <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg   <= in_op;
                slot_reg <= in_slot;
                work_reg <= in_work;
                lvl_reg  <= sat_lvl;
            end
            if (cmd.admit && work_reg != '0 && rem_reg[slot_reg] == '0)
            begin
                rem_reg[slot_reg]     <= work_reg;
                tlev_reg[slot_reg]    <= lvl_reg;
                started_reg[slot_reg] <= 1'b0;
                if (ne_reg[lvl_reg])
                    link_reg[tail_reg[lvl_reg]] <= slot_reg;
                else
                    head_reg[lvl_reg] <= slot_reg;
                tail_reg[lvl_reg] <= slot_reg;
                ne_reg[lvl_reg]   <= 1'b1;
            end
            if (cmd.requeue && exp_v_reg)
            begin
                if (ne_reg[tlev_reg[exp_reg]])
                    link_reg[tail_reg[tlev_reg[exp_reg]]] <= exp_reg;
                else
                    head_reg[tlev_reg[exp_reg]] <= exp_reg;
                tail_reg[tlev_reg[exp_reg]] <= exp_reg;
                ne_reg[tlev_reg[exp_reg]]   <= 1'b1;
                exp_v_reg <= 1'b0;
            end
            if (cmd.preempt && cur_v_reg && found && best < cur_lvl_reg)
            begin
                if (ne_reg[cur_lvl_reg])
                    link_reg[cur_reg] <= head_reg[cur_lvl_reg];
                else
                    tail_reg[cur_lvl_reg] <= cur_reg;
                head_reg[cur_lvl_reg] <= cur_reg;
                ne_reg[cur_lvl_reg]   <= 1'b1;
                cur_v_reg <= 1'b0;
                slice_reg <= '0;
            end
            if (cmd.run)
            begin
                time_reg <= time_reg + TIME_W'(1);
                if (!cur_v_reg && !found)
                    result_reg <= {time_reg + TIME_W'(1), 8'd0};
                else
                begin
                    if (!cur_v_reg)
                    begin
                        if (head_reg[best] == tail_reg[best])
                            ne_reg[best] <= 1'b0;
                        else
                            head_reg[best] <= link_reg[head_reg[best]];
                        cur_lvl_reg        <= best;
                        started_reg[pick]  <= 1'b1;
                        last_v_reg         <= 1'b1;
                        last_reg           <= pick;
                    end
                    rem_reg[pick] <= rem_dec;
                    result_reg <= {time_reg + TIME_W'(1),
                        !cur_v_reg && last_v_reg && last_reg != pick,
                        !cur_v_reg && !started_reg[pick],
                        rem_dec == '0, 4'(pick), 1'b1};
                    if (rem_dec == '0)
                    begin
                        cur_v_reg <= 1'b0;
                        slice_reg <= '0;
                    end
                    else if (slice_inc >= quantum)
                    begin
                        exp_v_reg <= 1'b1;
                        exp_reg   <= pick;
                        cur_v_reg <= 1'b0;
                        slice_reg <= '0;
                    end
                    else
                    begin
                        cur_v_reg <= 1'b1;
                        cur_reg   <= pick;
                        slice_reg <= slice_inc;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* sv/mlq_ctrl.sv */
// Controller of the scheduler: sequences load, admit and tick phases and
// owns the input and output handshakes. Depends on mlq_pkg.
`default_nettype none
module mlq_ctrl
    import mlq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire mlq_stat_t stat,
    output mlq_cmd_t       cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_REQ  = 3'd2;
    localparam logic [2:0] S_PRE  = 3'd3;
    localparam logic [2:0] S_RUN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    // Next state only waits on the output when a result is still held.
    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (stat.is_tick)
                begin
                    if (!ov_next)
                        state_next = S_REQ;
                end
                else
                begin
                    cmd.admit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REQ:
            begin
                cmd.requeue = 1'b1;
                state_next  = S_PRE;
            end
            S_PRE:
            begin
                cmd.preempt = 1'b1;
                state_next  = S_RUN;
            end
            S_RUN:
            begin
                cmd.run    = 1'b1;
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

/* sv/multilevel_queue_rr_scheduler_unit.sv */
// Multilevel queue round-robin scheduler, top level.
// An admit passes through the load and decode phases; a tick result is raised
// after decode, requeue, preempt and run. One item is in work at a time, so a
// new item is taken only once the phase sequencer is back in idle; a tick
// also waits in decode while the previous result has not been taken.
// rst_n clears all queues, tasks and time at once; quantum resets to 4.
// Depends on mlq_pkg, mlq_ctrl and mlq_datapath.
`default_nettype none
module multilevel_queue_rr_scheduler_unit
    import mlq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // operation, task_slot[3:0], work_amount[15:0],
                                        // priority_level[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // busy_res, running_slot[3:0], finished,
                                        // first_dispatch, context_switch,
                                        // tick_time[31:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    mlq_cmd_t           cmd;
    mlq_stat_t          stat;
    logic [QUANT_W-1:0] quantum_reg;
    logic [TIME_W+7:0]  result;

    // Configuration register; a zero quantum behaves as one by the compare.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quantum_reg <= QUANTUM_RESET;
        else if (psel && penable && pwrite && paddr == REG_QUANTUM)
            quantum_reg <= pwdata[QUANT_W-1:0];
    end
    assign prdata = (paddr == REG_QUANTUM) ? {16'd0, quantum_reg} : 32'd0;

    mlq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mlq_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .in_op   (s_tdata[0]),
        .in_slot (s_tdata[4:1]),
        .in_work (s_tdata[20:5]),
        .in_level(s_tdata[23:21]),
        .quantum (quantum_reg),
        .result  (result)
    );

    assign m_tdata = result;

    // The run phase always leaves a result waiting on the output.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run |=> m_tvalid)
        else $error("result not raised after run phase");
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.admit, cmd.requeue, cmd.preempt, cmd.run}) <= 1)
        else $error("more than one phase active");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> s_tready)
        else $error("load outside idle");
endmodule
`default_nettype wire
